// ===== design/random_permutation_engine_defines.svh =====
// assertion macros for the permutation engine checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RANDOM_PERMUTATION_ENGINE_DEFINES_SVH
`define RANDOM_PERMUTATION_ENGINE_DEFINES_SVH

// implication into the next cycle
`define RPE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication in the same cycle
`define RPE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/rpe_pkg.sv =====
// shared types and constants of the permutation engine
// no dependencies
`default_nettype none

package rpe_pkg;

    localparam int DEPTH_DEFAULT         = 64;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int BASE_W  = 16;
    localparam int SRC_W   = 17;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic [FRAC_W-1:0]         random_fraction;
        logic                      last_item;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] shuffled_value;
        logic [SRC_W-1:0]          source_index;
        logic                      last_result;
        logic                      overflow;
    } result_t;

    // per-cell control for one clock
    typedef struct packed {
        logic load;     // write the incoming element into this cell
        logic compact;  // take element from the upper neighbor
        logic advance;  // take fraction from the upper neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rpe_cell.sv =====
// one cell of the shuffle chain: an element with its load position and a fraction slot
// depends on rpe_pkg
`default_nettype none

module rpe_cell
    import rpe_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [VALUE_W-1:0] load_value,
    input  logic [FRAC_W-1:0]  load_frac,
    input  logic [IDX_W-1:0]   load_pos,
    input  logic [VALUE_W-1:0] nb_value,
    input  logic [IDX_W-1:0]   nb_pos,
    input  logic [FRAC_W-1:0]  nb_frac,
    output logic [VALUE_W-1:0] value,
    output logic [IDX_W-1:0]   pos,
    output logic [FRAC_W-1:0]  frac
);

    logic [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [FRAC_W-1:0]  frac_reg;

    // elements close the gap left by a draw, fractions move one slot per draw
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= load_value;
            pos_reg   <= load_pos;
        end
        else if (ctrl.compact)
        begin
            value_reg <= nb_value;
            pos_reg   <= nb_pos;
        end

        if (ctrl.load)
        begin
            frac_reg <= load_frac;
        end
        else if (ctrl.advance)
        begin
            frac_reg <= nb_frac;
        end
    end

    assign value = value_reg;
    assign pos   = pos_reg;
    assign frac  = frac_reg;

endmodule

`default_nettype wire

// ===== design/random_permutation_engine.sv =====
// Shuffles a run of up to DEPTH elements by the strike-out method. Each element is
// loaded with a random fraction by one transaction; the transaction marked
// last closes the run (loads past DEPTH are dropped and flag overflow on every result).
// The input then stalls while the run drains at one result per cycle when the output
// is not stalled. The drain rate is set by the chain of cells: on each draw the k-th
// remaining element is picked and the cells above it shift down by one. There is no
// clearing pass after reset.
// Depends on rpe_pkg and rpe_cell.
`default_nettype none

module random_permutation_engine
    import rpe_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result_data,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PROD_W = CNT_W + FRAC_W;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              ovf_reg,    ovf_next;
    logic [BASE_W-1:0] base_reg;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [IDX_W-1:0]   cell_pos   [DEPTH];
    logic [FRAC_W-1:0]  cell_frac  [DEPTH];
    cell_ctrl_t         cell_ctrl  [DEPTH];

    logic               accept;
    logic               emit;
    logic               room;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  k_full;
    logic [IDX_W-1:0]   k;
    logic [VALUE_W-1:0] sel_value;
    logic [IDX_W-1:0]   sel_pos;

    assign item_stall   = (state_reg == ST_DRAIN);
    assign accept       = item_valid && !item_stall;
    assign emit         = (state_reg == ST_DRAIN) && (!result_valid_reg || !result_stall);
    assign room         = (count_reg < CNT_W'(DEPTH));
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // draw position from the remaining count and the fraction at the head of the chain
    assign prod   = PROD_W'(remain_reg) * PROD_W'(cell_frac[0]);
    assign k_full = prod >> FRACTION_BITS;

    always_comb
    begin
        if (k_full >= PROD_W'(remain_reg))
        begin
            k = IDX_W'(remain_reg - CNT_W'(1));
        end
        else
        begin
            k = k_full[IDX_W-1:0];
        end
    end

    always_comb
    begin
        sel_value = cell_value[0];
        sel_pos   = cell_pos[0];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (k == IDX_W'(i))
            begin
                sel_value = cell_value[i];
                sel_pos   = cell_pos[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].load    = accept && room && (count_reg == CNT_W'(i));
            cell_ctrl[i].compact = emit && (IDX_W'(i) >= k);
            cell_ctrl[i].advance = emit;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_W-1:0] nb_value;
        logic [IDX_W-1:0]   nb_pos;
        logic [FRAC_W-1:0]  nb_frac;

        if (g == DEPTH - 1)
        begin : g_top
            assign nb_value = cell_value[g];
            assign nb_pos   = cell_pos[g];
            assign nb_frac  = cell_frac[g];
        end
        else
        begin : g_mid
            assign nb_value = cell_value[g+1];
            assign nb_pos   = cell_pos[g+1];
            assign nb_frac  = cell_frac[g+1];
        end

        rpe_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[g]),
            .load_value(item_data.element_value),
            .load_frac (item_data.random_fraction),
            .load_pos  (count_reg[IDX_W-1:0]),
            .nb_value  (nb_value),
            .nb_pos    (nb_pos),
            .nb_frac   (nb_frac),
            .value     (cell_value[g]),
            .pos       (cell_pos[g]),
            .frac      (cell_frac[g])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        remain_next       = remain_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item_data.last_item)
                    begin
                        state_next  = ST_DRAIN;
                        remain_next = room ? count_reg + CNT_W'(1) : count_reg;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    result_valid_next          = 1'b1;
                    result_next.shuffled_value = sel_value;
                    result_next.source_index   = {1'b0, base_reg} + SRC_W'(sel_pos);
                    result_next.last_result    = (remain_reg == CNT_W'(1));
                    result_next.overflow       = ovf_reg;
                    remain_next                = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            remain_reg       <= '0;
            ovf_reg          <= 1'b0;
            base_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            remain_reg       <= remain_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== design/rpe_checker.sv =====
// port-level checks of the permutation engine, bound to the top level
// depends on rpe_pkg and random_permutation_engine_defines.svh
`default_nettype none
`include "random_permutation_engine_defines.svh"

module rpe_checker
    import rpe_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item_data,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    // the transaction that closes a run stops loading until the run has drained
    `RPE_ASSERT_NEXT(a_last_closes, item_valid && !item_stall && item_data.last_item, item_stall, "input not stalled after last item")

    // loading stops only because a run was closed
    `RPE_ASSERT_NOW(a_stall_cause, $rose(item_stall), $past(item_valid && item_data.last_item), "input stalled without a last item")

    `RPE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")

    // overflow is one flag for the whole run
    `RPE_ASSERT_NEXT(a_ovf_run, result_valid && !result_stall && !result_data.last_result, !result_valid || (result_data.overflow == $past(result_data.overflow)), "overflow changed within a run")

endmodule

bind random_permutation_engine rpe_checker u_rpe_checker (.*);

`default_nettype wire

// ===== sim/rpe_shuffle_checker.sv =====
// result checker for random_permutation_engine: tracks index_base, rebuilds each
// run from the loaded transactions and predicts the strike-out draw order
// depends on rpe_pkg
`default_nettype none

module rpe_shuffle_checker
    import rpe_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  item_t             item_data,
    input  logic              result_valid,
    input  logic              result_stall,
    input  result_t           result_data,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata,
    output int                mismatches,
    output int                outstanding,
    output int                results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;

    logic signed [VALUE_W-1:0] run_values    [DEPTH];
    logic [FRAC_W-1:0]         run_fractions [DEPTH];
    int                        run_len      = 0;
    bit                        run_overflow = 1'b0;
    logic [BASE_W-1:0]         index_base   = '0;
    result_t                   draw_q [$];
    int                        err_count    = 0;
    int                        got_count    = 0;

    assign mismatches      = err_count;
    assign results_checked = got_count;

    task automatic flag_mismatch(input string what);
        if (err_count < MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, what);
        err_count++;
    endtask

    // strike-out draw over the stored run, one result per loaded element
    task automatic predict_shuffle_run();
        bit          taken [DEPTH];
        int          remaining;
        int          k;
        int          seen;
        int          pick;
        logic [63:0] scaled;
        result_t     r;
        foreach (taken[i])
            taken[i] = 1'b0;
        remaining = run_len;
        for (int j = 0; j < run_len; j++)
        begin
            scaled = (64'(remaining) * 64'(run_fractions[j])) >> FRACTION_BITS;
            // only reachable when the fraction is wider than FRACTION_BITS
            k = (scaled >= 64'(remaining)) ? remaining - 1 : int'(scaled);
            seen = 0;
            pick = 0;
            for (int i = 0; i < run_len; i++)
            begin
                if (!taken[i])
                begin
                    if (seen == k)
                    begin
                        pick = i;
                        break;
                    end
                    seen++;
                end
            end
            taken[pick]      = 1'b1;
            remaining--;
            r.shuffled_value = run_values[pick];
            r.source_index   = SRC_W'(index_base) + SRC_W'(pick);
            r.last_result    = (j == run_len - 1);
            r.overflow       = run_overflow;
            draw_q.push_back(r);
        end
        run_len      = 0;
        run_overflow = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            index_base   = '0;
            run_len      = 0;
            run_overflow = 1'b0;
            draw_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                index_base = cfg_wdata;
            if (item_valid && !item_stall)
            begin
                if (run_len < DEPTH)
                begin
                    run_values[run_len]    = item_data.element_value;
                    run_fractions[run_len] = item_data.random_fraction;
                    run_len++;
                end
                else
                    run_overflow = 1'b1;
                if (item_data.last_item)
                    predict_shuffle_run();
            end
            if (result_valid && !result_stall)
            begin
                got_count++;
                if (draw_q.size() == 0)
                    flag_mismatch($sformatf("unexpected result value %h index %h",
                                            result_data.shuffled_value,
                                            result_data.source_index));
                else
                begin
                    want = draw_q.pop_front();
                    if (result_data.shuffled_value !== want.shuffled_value)
                        flag_mismatch($sformatf("shuffled_value got %h want %h",
                                                result_data.shuffled_value,
                                                want.shuffled_value));
                    if (result_data.source_index !== want.source_index)
                        flag_mismatch($sformatf("source_index got %h want %h",
                                                result_data.source_index,
                                                want.source_index));
                    if (result_data.last_result !== want.last_result)
                        flag_mismatch($sformatf("last_result got %b want %b",
                                                result_data.last_result,
                                                want.last_result));
                    if (result_data.overflow !== want.overflow)
                        flag_mismatch($sformatf("overflow got %b want %b",
                                                result_data.overflow, want.overflow));
                end
            end
            outstanding <= draw_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/random_permutation_engine_tb.sv =====
// top-level testbench for random_permutation_engine: drives runs to shuffle,
// stalls the result side and reports the verdict
// depends on rpe_pkg, rpe_shuffle_checker and the engine rtl
`default_nettype none

module random_permutation_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpe_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int FRACTION_BITS  = FRACTION_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FINAL_CYCLES   = 20;
    localparam int SMALL_BUDGET   = 25;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_e;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item_data    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result_data;
    logic              cfg_we       = 1'b0;
    logic [BASE_W-1:0] cfg_wdata    = '0;

    int mismatches;
    int outstanding;
    int results_checked;

    int burst_left    = 0;
    int items_sent    = 0;
    int runs_sent     = 0;
    int overflow_runs = 0;
    int quiet_cycles  = 0;

    stall_mode_e stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;

    random_permutation_engine #(
        .DEPTH         (DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    rpe_shuffle_checker #(
        .DEPTH         (DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item_data       (item_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_data     (result_data),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side stall pattern, switching between random stall styles
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 6);
            default:
            begin
                if (hold_left != 0)
                begin
                    hold_left--;
                    result_stall <= 1'b1;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    hold_left = $urandom_range(1, 8);
                    result_stall <= 1'b1;
                end
                else
                    result_stall <= 1'b0;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one load transaction; valid stays up when the burst goes on
    task automatic send_load(input logic [VALUE_W-1:0] value,
                             input logic [FRAC_W-1:0] fraction, input logic last);
        item_t it;
        int    gap;
        it.element_value   = value;
        it.random_fraction = fraction;
        it.last_item       = last;
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_run(input int len);
        logic [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]  fraction;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       fraction = '0;
                1:       fraction = '1;
                default: fraction = FRAC_W'($urandom_range(0, 65535));
            endcase
            send_load(value, fraction, i == len - 1);
        end
        runs_sent++;
        if (len > DEPTH)
            overflow_runs++;
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_index_base(input logic [BASE_W-1:0] base);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [BASE_W-1:0] bases     [4];
        int                big_runs  [4];
        int                budget;
        int                len;
        bases[0]    = '0;
        bases[1]    = '1;
        bases[2]    = BASE_W'($urandom);
        bases[3]    = 16'h8000;
        big_runs[0] = 0;
        big_runs[1] = DEPTH;
        big_runs[2] = DEPTH + 2;
        big_runs[3] = DEPTH + 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_index_base(bases[0]);

        // single-element runs at the value extremes
        send_load(32'h7FFF_FFFF, 16'hFFFF, 1'b1);
        send_load(32'h8000_0000, 16'h0000, 1'b1);
        // zero fractions keep load order
        send_load(32'd1, 16'h0000, 1'b0);
        send_load(32'd2, 16'h0000, 1'b0);
        send_load(32'd3, 16'h0000, 1'b0);
        send_load(32'd4, 16'h0000, 1'b1);
        // full-scale fractions always take the last element left
        send_load(-32'sd1, 16'hFFFF, 1'b0);
        send_load(-32'sd2, 16'hFFFF, 1'b0);
        send_load(-32'sd3, 16'hFFFF, 1'b0);
        send_load(-32'sd4, 16'hFFFF, 1'b1);
        send_load(32'h0000_0000, 16'h8000, 1'b0);
        send_load(32'hFFFF_FFFF, 16'h0000, 1'b0);
        send_load(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_load(32'h8000_0000, 16'h4000, 1'b0);
        send_load(32'h5555_5555, 16'hC000, 1'b0);
        send_load(32'hAAAA_AAAA, 16'h0001, 1'b1);
        send_load(32'h1234_5678, 16'hFFFF, 1'b0);
        send_load(32'h8765_4321, 16'h0000, 1'b1);
        runs_sent += 6;

        for (int p = 1; p < 4; p++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            set_index_base(bases[p]);
            send_random_run(big_runs[p]);
            budget = SMALL_BUDGET;
            while (budget > 0)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                if (len > budget)
                    len = budget;
                send_random_run(len);
                budget -= len;
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (FINAL_CYCLES) @(posedge clk);
        $display("shuffled %0d runs (%0d with dropped loads) from %0d load transactions",
                 runs_sent, overflow_runs, items_sent);
        $display("checked %0d results across 4 index_base settings", results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
